@@ rtl/gtr_pkg.sv @@
// Shared widths, codes, control words and microcode ROM of the geared throttle ramp.
package gtr_pkg;

   localparam int PULSE_W    = 12;
   localparam int GEAR_W     = 3;
   localparam int GCNT_W     = 4;
   localparam int IDLE_W     = 16;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int MAX_GEARS  = 8;
   localparam int RAMP_STEPS = 10;
   localparam int IDLE_LIMIT = 500;

   localparam logic [PULSE_W-1:0] STANDBY_RST   = 12'd1500;
   localparam logic [PULSE_W-1:0] FORWARD_RST   = 12'd2000;
   localparam logic [PULSE_W-1:0] REVERSE_RST   = 12'd1000;
   localparam logic [GCNT_W-1:0]  GEAR_CNT_RST  = 4'd5;
   localparam logic [PULSE_W-1:0] PULSE_MAX     = '1;

   localparam logic [CMD_W-1:0] GEAR_KEEP   = 2'd0;
   localparam logic [CMD_W-1:0] GEAR_UP     = 2'd1;
   localparam logic [CMD_W-1:0] GEAR_LOWER  = 2'd2;

   localparam logic [CMD_W-1:0] DRIVE_NONE  = 2'd0;
   localparam logic [CMD_W-1:0] DRIVE_FWD   = 2'd1;
   localparam logic [CMD_W-1:0] DRIVE_REV   = 2'd2;
   localparam logic [CMD_W-1:0] DRIVE_BRAKE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STANDBY  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_CNT = 2'd3;

   // divider: signed dividend, unsigned divisor, magnitude worked one bit a cycle
   localparam int DVD_W = 18;
   localparam int MAG_W = 16;
   localparam int DVS_W = 4;
   localparam int CNT_W = $clog2(MAG_W);
   localparam int SUM_W = 19;

   // ramp step: span magnitude times a rounded-up reciprocal of RAMP_STEPS
   localparam int STEP_MAG_W = 15;
   localparam int STEP_SH    = STEP_MAG_W + $clog2(RAMP_STEPS);
   localparam int RECIP_W    = STEP_MAG_W + 2;
   localparam int PROD_W     = STEP_MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] STEP_RECIP =
      RECIP_W'((2**STEP_SH + RAMP_STEPS - 1) / RAMP_STEPS);

   localparam int PC_W   = 3;
   localparam int OP_W   = 3;
   localparam int COND_W = 3;

   localparam logic [OP_W-1:0] OP_NOP       = 3'd0;
   localparam logic [OP_W-1:0] OP_ACCEPT    = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD_UNIT = 3'd2;
   localparam logic [OP_W-1:0] OP_SPAN      = 3'd3;
   localparam logic [OP_W-1:0] OP_LOAD_STEP = 3'd4;
   localparam logic [OP_W-1:0] OP_APPLY     = 3'd5;
   localparam logic [OP_W-1:0] OP_EMIT      = 3'd6;
   localparam logic [OP_W-1:0] OP_SCALE     = 3'd7;

   localparam logic [COND_W-1:0] C_NEXT     = 3'd0;
   localparam logic [COND_W-1:0] C_NO_REQ   = 3'd1;
   localparam logic [COND_W-1:0] C_HOLD     = 3'd2;
   localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd3;
   localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd4;

   localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] PC_UNIT  = 3'd1;
   localparam logic [PC_W-1:0] PC_DIV1  = 3'd2;
   localparam logic [PC_W-1:0] PC_SPAN  = 3'd3;
   localparam logic [PC_W-1:0] PC_STEP  = 3'd4;
   localparam logic [PC_W-1:0] PC_SCALE = 3'd5;
   localparam logic [PC_W-1:0] PC_APPLY = 3'd6;
   localparam logic [PC_W-1:0] PC_EMIT  = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic hold;
      logic div_busy;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic                    start;
      logic signed [DVD_W-1:0] dividend;
      logic [DVS_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                    busy;
      logic signed [DVD_W-1:0] quotient;
   } div_rsp_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         PC_IDLE:  w = '{op: OP_ACCEPT,    cond: C_NO_REQ,   target: PC_IDLE};
         PC_UNIT:  w = '{op: OP_LOAD_UNIT, cond: C_HOLD,     target: PC_APPLY};
         PC_DIV1:  w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: PC_DIV1};
         PC_SPAN:  w = '{op: OP_SPAN,      cond: C_NEXT,     target: PC_IDLE};
         PC_STEP:  w = '{op: OP_LOAD_STEP, cond: C_NEXT,     target: PC_IDLE};
         PC_SCALE: w = '{op: OP_SCALE,     cond: C_NEXT,     target: PC_IDLE};
         PC_APPLY: w = '{op: OP_APPLY,     cond: C_NEXT,     target: PC_IDLE};
         PC_EMIT:  w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: PC_EMIT};
         default:  w = '{op: OP_NOP,       cond: C_NEXT,     target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/gtr_div.sv @@
// Iterative signed-by-unsigned divider, truncating toward zero.
module gtr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gtr_pkg::div_req_type div_req,
   output gtr_pkg::div_rsp_type div_rsp
);

   logic                         busy_ff, busy_in;
   logic [gtr_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [gtr_pkg::MAG_W-1:0]    quo_ff, quo_in;
   logic [gtr_pkg::DVS_W-1:0]    rem_ff, rem_in;
   logic [gtr_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic                         neg_ff, neg_in;
   logic signed [gtr_pkg::DVD_W-1:0] abs_dvd;
   logic [gtr_pkg::DVS_W:0]      trial;
   logic [gtr_pkg::DVS_W:0]      diff;
   logic                         fits;

   always_comb begin
      abs_dvd = div_req.dividend[gtr_pkg::DVD_W-1] ? -div_req.dividend : div_req.dividend;
      trial   = {rem_ff, quo_ff[gtr_pkg::MAG_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = abs_dvd[gtr_pkg::MAG_W-1:0];
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         neg_in  = div_req.dividend[gtr_pkg::DVD_W-1];
      end else if (busy_ff) begin
         quo_in = {quo_ff[gtr_pkg::MAG_W-2:0], fits};
         rem_in = fits ? diff[gtr_pkg::DVS_W-1:0] : trial[gtr_pkg::DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gtr_pkg::CNT_W'(gtr_pkg::MAG_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      div_rsp.busy     = busy_ff;
      div_rsp.quotient = neg_ff
         ? -$signed({{(gtr_pkg::DVD_W-gtr_pkg::MAG_W){1'b0}}, quo_ff})
         :  $signed({{(gtr_pkg::DVD_W-gtr_pkg::MAG_W){1'b0}}, quo_ff});
   end

`ifndef SYNTH
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(div_req.start))
      else $error("divider went busy without a start");
`endif

endmodule

@@ rtl/gtr_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module gtr_seq (
   input  logic                clock,
   input  logic                reset,
   input  gtr_pkg::status_type status,
   output gtr_pkg::ctrl_type   ctrl
);

   logic [gtr_pkg::PC_W-1:0] pc_ff, pc_in;
   gtr_pkg::ucode_type       word;
   logic                     take;

   always_comb begin
      word = gtr_pkg::ucode_rom(pc_ff);
      unique case (word.cond)
         gtr_pkg::C_NEXT:     take = 1'b0;
         gtr_pkg::C_NO_REQ:   take = !status.req_valid;
         gtr_pkg::C_HOLD:     take = status.hold;
         gtr_pkg::C_DIV_BUSY: take = status.div_busy;
         gtr_pkg::C_OUT_BUSY: take = status.out_busy;
         default:             take = 1'b0;
      endcase
      pc_in   = take ? word.target : pc_ff + 1'b1;
      ctrl.op = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= gtr_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

`ifndef SYNTH
   a_apply_after_div: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == gtr_pkg::OP_APPLY) |-> !status.div_busy)
      else $error("ramp applied while divider still busy");

   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == gtr_pkg::OP_ACCEPT && status.req_valid) |=> (ctrl.op != gtr_pkg::OP_ACCEPT))
      else $error("second item taken straight after an accept");
`endif

endmodule

@@ rtl/gtr_datapath.sv @@
// Datapath: config registers, gear and idle state, ramp arithmetic and result register.
module gtr_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  gtr_pkg::ctrl_type               ctrl,
   output gtr_pkg::status_type             status,
   output gtr_pkg::div_req_type            div_req,
   input  gtr_pkg::div_rsp_type            div_rsp,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gtr_pkg::CMD_W-1:0]       req_gear_cmd,
   input  logic [gtr_pkg::CMD_W-1:0]       req_drive_cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gtr_pkg::PULSE_W-1:0]     rsp_pulse_out,
   output logic [gtr_pkg::GEAR_W-1:0]      rsp_gear_out,
   output logic                            rsp_idle_brake,
   input  logic                            csr_we,
   input  logic [gtr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gtr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [gtr_pkg::PULSE_W-1:0] standby_ff, forward_ff, reverse_ff;
   logic [gtr_pkg::GCNT_W-1:0]  gear_cnt_ff;
   logic [gtr_pkg::PULSE_W-1:0] pulse_ff, pulse_in;
   logic [gtr_pkg::GEAR_W-1:0]  gear_ff, gear_in;
   logic [gtr_pkg::IDLE_W-1:0]  idle_ff, idle_in;
   logic [gtr_pkg::CMD_W-1:0]   mode_ff, mode_in;
   logic                        forced_ff, forced_in;
   logic signed [gtr_pkg::DVD_W-1:0] span_ff, span_in;
   logic [gtr_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [gtr_pkg::DVD_W-1:0] step_ff, step_in;
   logic                        rsp_valid_ff;
   logic [gtr_pkg::PULSE_W-1:0] rsp_pulse_ff;
   logic [gtr_pkg::GEAR_W-1:0]  rsp_gear_ff;
   logic                        rsp_brake_ff;

   logic [gtr_pkg::GCNT_W-1:0]  n_eff;
   logic [gtr_pkg::IDLE_W-1:0]  idle_inc;
   logic                        accept, emit, out_free;
   logic signed [gtr_pkg::DVD_W-1:0] unit_q;
   logic signed [gtr_pkg::DVD_W-1:0] gear_mul;
   logic [gtr_pkg::STEP_MAG_W-1:0] span_mag, step_mag;
   logic signed [gtr_pkg::SUM_W-1:0] s_ext, p_ext, span_ext, step_ext, target, next_p;
   logic signed [gtr_pkg::DVD_W-1:0] fwd_diff, rev_diff;

   always_comb begin
      if (gear_cnt_ff == '0) begin
         n_eff = gtr_pkg::GCNT_W'(1);
      end else if (gear_cnt_ff > gtr_pkg::GCNT_W'(gtr_pkg::MAX_GEARS)) begin
         n_eff = gtr_pkg::GCNT_W'(gtr_pkg::MAX_GEARS);
      end else begin
         n_eff = gear_cnt_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = (ctrl.op == gtr_pkg::OP_ACCEPT) && req_valid;
   assign emit     = (ctrl.op == gtr_pkg::OP_EMIT) && out_free;
   assign idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;

   // gear, idle timeout and effective drive mode at accept
   always_comb begin
      gear_in   = gear_ff;
      idle_in   = idle_ff;
      mode_in   = mode_ff;
      forced_in = forced_ff;
      if (accept) begin
         unique case (req_gear_cmd)
            gtr_pkg::GEAR_UP: begin
               if ({1'b0, gear_ff} < n_eff - 1'b1) begin
                  gear_in = gear_ff + 1'b1;
               end
            end
            gtr_pkg::GEAR_LOWER: begin
               if (gear_ff != '0) begin
                  gear_in = gear_ff - 1'b1;
               end
            end
            default: gear_in = gear_ff;
         endcase
         if (req_drive_cmd == gtr_pkg::DRIVE_NONE) begin
            idle_in   = idle_inc;
            forced_in = idle_inc > gtr_pkg::IDLE_W'(gtr_pkg::IDLE_LIMIT);
            mode_in   = forced_in ? gtr_pkg::DRIVE_BRAKE : gtr_pkg::DRIVE_NONE;
         end else begin
            idle_in   = '0;
            forced_in = 1'b0;
            mode_in   = req_drive_cmd;
         end
      end
   end

   // divider requests
   always_comb begin
      fwd_diff = $signed({{(gtr_pkg::DVD_W-gtr_pkg::PULSE_W){1'b0}}, forward_ff})
               - $signed({{(gtr_pkg::DVD_W-gtr_pkg::PULSE_W){1'b0}}, standby_ff});
      rev_diff = $signed({{(gtr_pkg::DVD_W-gtr_pkg::PULSE_W){1'b0}}, standby_ff})
               - $signed({{(gtr_pkg::DVD_W-gtr_pkg::PULSE_W){1'b0}}, reverse_ff});
      div_req.start    = (ctrl.op == gtr_pkg::OP_LOAD_UNIT) && !status.hold;
      div_req.dividend = (mode_ff == gtr_pkg::DRIVE_FWD) ? fwd_diff : rev_diff;
      div_req.divisor  = n_eff;
   end

   // span = unit * (gear + 1)
   always_comb begin
      unit_q   = div_rsp.quotient;
      gear_mul = $signed({{(gtr_pkg::DVD_W-gtr_pkg::GEAR_W){1'b0}}, gear_ff}
                         + gtr_pkg::DVD_W'(1));
      span_in  = span_ff;
      if (ctrl.op == gtr_pkg::OP_SPAN) begin
         span_in = unit_q * gear_mul;
      end
   end

   // step = span / RAMP_STEPS, truncated toward zero
   always_comb begin
      span_mag = span_ff[gtr_pkg::DVD_W-1] ? gtr_pkg::STEP_MAG_W'(-span_ff)
                                            : gtr_pkg::STEP_MAG_W'(span_ff);
      step_mag = gtr_pkg::STEP_MAG_W'(prod_ff >> gtr_pkg::STEP_SH);
      prod_in  = prod_ff;
      step_in  = step_ff;
      if (ctrl.op == gtr_pkg::OP_LOAD_STEP) begin
         prod_in = gtr_pkg::PROD_W'(span_mag) * gtr_pkg::PROD_W'(gtr_pkg::STEP_RECIP);
      end
      if (ctrl.op == gtr_pkg::OP_SCALE) begin
         step_in = span_ff[gtr_pkg::DVD_W-1]
            ? -$signed({{(gtr_pkg::DVD_W-gtr_pkg::STEP_MAG_W){1'b0}}, step_mag})
            :  $signed({{(gtr_pkg::DVD_W-gtr_pkg::STEP_MAG_W){1'b0}}, step_mag});
      end
   end

   // ramp toward target and saturate; brake returns to standby, no drive holds
   always_comb begin
      s_ext    = $signed({{(gtr_pkg::SUM_W-gtr_pkg::PULSE_W){1'b0}}, standby_ff});
      p_ext    = $signed({{(gtr_pkg::SUM_W-gtr_pkg::PULSE_W){1'b0}}, pulse_ff});
      span_ext = gtr_pkg::SUM_W'(span_ff);
      step_ext = gtr_pkg::SUM_W'(step_ff);
      if (mode_ff == gtr_pkg::DRIVE_FWD) begin
         target = s_ext + span_ext;
         next_p = (p_ext < target - step_ext) ? p_ext + step_ext : target;
      end else begin
         target = s_ext - span_ext;
         next_p = (p_ext > target + step_ext) ? p_ext - step_ext : target;
      end
      pulse_in = pulse_ff;
      if (ctrl.op == gtr_pkg::OP_APPLY) begin
         unique case (mode_ff)
            gtr_pkg::DRIVE_FWD, gtr_pkg::DRIVE_REV: begin
               if (next_p < 0) begin
                  pulse_in = '0;
               end else if (next_p > $signed({{(gtr_pkg::SUM_W-gtr_pkg::PULSE_W){1'b0}},
                                              gtr_pkg::PULSE_MAX})) begin
                  pulse_in = gtr_pkg::PULSE_MAX;
               end else begin
                  pulse_in = next_p[gtr_pkg::PULSE_W-1:0];
               end
            end
            gtr_pkg::DRIVE_BRAKE: pulse_in = standby_ff;
            default:              pulse_in = pulse_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         standby_ff   <= gtr_pkg::STANDBY_RST;
         forward_ff   <= gtr_pkg::FORWARD_RST;
         reverse_ff   <= gtr_pkg::REVERSE_RST;
         gear_cnt_ff  <= gtr_pkg::GEAR_CNT_RST;
         pulse_ff     <= gtr_pkg::STANDBY_RST;
         gear_ff      <= '0;
         idle_ff      <= '0;
         mode_ff      <= gtr_pkg::DRIVE_NONE;
         forced_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               gtr_pkg::CSR_STANDBY:  standby_ff  <= csr_wdata;
               gtr_pkg::CSR_FORWARD:  forward_ff  <= csr_wdata;
               gtr_pkg::CSR_REVERSE:  reverse_ff  <= csr_wdata;
               gtr_pkg::CSR_GEAR_CNT: gear_cnt_ff <= csr_wdata[gtr_pkg::GCNT_W-1:0];
               default:               gear_cnt_ff <= gear_cnt_ff;
            endcase
         end
         pulse_ff  <= pulse_in;
         gear_ff   <= gear_in;
         idle_ff   <= idle_in;
         mode_ff   <= mode_in;
         forced_ff <= forced_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      span_ff <= span_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      if (emit) begin
         rsp_pulse_ff <= pulse_ff;
         rsp_gear_ff  <= gear_ff;
         rsp_brake_ff <= forced_ff;
      end
   end

   always_comb begin
      status.req_valid = req_valid;
      status.hold      = (mode_ff == gtr_pkg::DRIVE_NONE) || (mode_ff == gtr_pkg::DRIVE_BRAKE);
      status.div_busy  = div_rsp.busy;
      status.out_busy  = !out_free;
   end

   assign req_ready      = (ctrl.op == gtr_pkg::OP_ACCEPT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pulse_out  = rsp_pulse_ff;
   assign rsp_gear_out   = rsp_gear_ff;
   assign rsp_idle_brake = rsp_brake_ff;

endmodule

@@ rtl/geared_throttle_ramp_top.sv @@
// Top level of the geared throttle ramp: sequencer, datapath and divider.
//
// One item per 1 ms tick: the gear event steps the gear within the configured
// count, the drive event ramps the pulse width toward the gear's forward or
// reverse target, or brakes it to standby; a long run of ticks without a drive
// event forces a brake and flags idle_brake. A ramping item runs the accept and
// divider-load steps, waits on the bit-serial divider for the gear unit, takes
// one step for the span and two for the reciprocal multiplication that yields
// the ramp step, then apply and emit; an item that holds or brakes runs only
// the accept, divider-load, apply and emit steps of the microcode sequence.
// The result waits in an output register; the next item is taken as soon as
// the sequence returns to its first step, and a stalled result only holds up
// the last step. Write the csr_ registers only while no item is in flight.
module geared_throttle_ramp_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gtr_pkg::CMD_W-1:0]       req_gear_cmd,
   input  logic [gtr_pkg::CMD_W-1:0]       req_drive_cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gtr_pkg::PULSE_W-1:0]     rsp_pulse_out,
   output logic [gtr_pkg::GEAR_W-1:0]      rsp_gear_out,
   output logic                            rsp_idle_brake,
   input  logic                            csr_we,
   input  logic [gtr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gtr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   gtr_pkg::ctrl_type    ctrl;
   gtr_pkg::status_type  status;
   gtr_pkg::div_req_type div_req;
   gtr_pkg::div_rsp_type div_rsp;

   gtr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   gtr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   gtr_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .status         (status),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_gear_cmd   (req_gear_cmd),
      .req_drive_cmd  (req_drive_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pulse_out  (rsp_pulse_out),
      .rsp_gear_out   (rsp_gear_out),
      .rsp_idle_brake (rsp_idle_brake),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

endmodule
